>>> hw/rtl/dapt_pkg.sv
// Shared constants, register codes and control types for the dual-axis PID tracker.
package dapt_pkg;

  localparam int unsigned GainW    = 16;
  localparam int unsigned CoordW   = 9;
  localparam int unsigned ErrW     = 10;
  localparam int unsigned DerW     = 11;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int          DriveLimit = 100;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgGainPX  = 3'd0,
    CfgGainIX  = 3'd1,
    CfgGainDX  = 3'd2,
    CfgGainPY  = 3'd3,
    CfgGainIY  = 3'd4,
    CfgGainDY  = 3'd5,
    CfgTargetX = 3'd6,
    CfgTargetY = 3'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [GainW-1:0]  RstGainPX  = 16'd218;
  localparam logic [GainW-1:0]  RstGainIX  = 16'd3;
  localparam logic [GainW-1:0]  RstGainDX  = 16'd282;
  localparam logic [GainW-1:0]  RstGainPY  = 16'd256;
  localparam logic [GainW-1:0]  RstGainIY  = 16'd3;
  localparam logic [GainW-1:0]  RstGainDY  = 16'd256;
  localparam logic [CoordW-1:0] RstTargetX = 9'd158;
  localparam logic [CoordW-1:0] RstTargetY = 9'd120;

  // Pipeline control shared by both axis lanes
  typedef struct packed {
    logic load_s1;     // item accepted: update loop state, fill stage 1
    logic present_s1;  // object flag of the item being accepted
    logic load_s2;     // move stage 1 into the product stage
    logic present_s2;  // object flag of the item in the product stage
  } lane_ctl_t;

endpackage

>>> hw/rtl/dapt_in_if.sv
// Input channel: one camera snapshot per item.
interface dapt_in_if;
  logic                           valid;
  logic                           ready;
  logic                           object_present;
  logic [dapt_pkg::CoordW-1:0]    centre_x;
  logic [dapt_pkg::CoordW-1:0]    centre_y;

  modport source (output valid, object_present, centre_x, centre_y, input ready);
  modport sink   (input valid, object_present, centre_x, centre_y, output ready);
endinterface

>>> hw/rtl/dapt_out_if.sv
// Output channel: motor drives and brake per item.
interface dapt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dapt_pkg::DriveW-1:0] drive_x;
  logic signed [dapt_pkg::DriveW-1:0] drive_y;
  logic                              brake;

  modport source (output valid, drive_x, drive_y, brake, input ready);
  modport sink   (input valid, drive_x, drive_y, brake, output ready);
endinterface

>>> hw/rtl/dual_axis_pid_tracker_core.sv
// Top level of the dual-axis PID tracker: config registers, lane control, two lanes, merge.
//
//   Channel  | Dir | Payload                             | Handshake
//   in_i     | in  | object_present, centre_x, centre_y  | valid/ready
//   out_o    | out | drive_x, drive_y, brake             | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_wdata_i              | cfg_we_i, no back-pressure
//
// One item per cycle sustained unless out_o stalls.
// The stages are: loop state update, gain products, then sum/saturate into the output register.
// The integral/previous-error update sits in the accept cycle, so items may follow back to back.
// Reset sets the gains and targets to their defaults and clears integrals and previous errors.
// A stalled output holds its item; empty stages in front of it still fill and accept input.
module dual_axis_pid_tracker_core #(
  parameter int unsigned IntegralBits = 21,
  parameter int unsigned GainFracBits = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dapt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dapt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  dapt_in_if.sink                         in_i,
  dapt_out_if.source                      out_o
);
  import dapt_pkg::*;

  // Configuration registers
  logic [GainW-1:0]  gain_p_x_q, gain_i_x_q, gain_d_x_q;
  logic [GainW-1:0]  gain_p_y_q, gain_i_y_q, gain_d_y_q;
  logic [CoordW-1:0] target_x_q, target_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_x_q <= RstGainPX;
      gain_i_x_q <= RstGainIX;
      gain_d_x_q <= RstGainDX;
      gain_p_y_q <= RstGainPY;
      gain_i_y_q <= RstGainIY;
      gain_d_y_q <= RstGainDY;
      target_x_q <= RstTargetX;
      target_y_q <= RstTargetY;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgGainPX:  gain_p_x_q <= cfg_wdata_i;
        CfgGainIX:  gain_i_x_q <= cfg_wdata_i;
        CfgGainDX:  gain_d_x_q <= cfg_wdata_i;
        CfgGainPY:  gain_p_y_q <= cfg_wdata_i;
        CfgGainIY:  gain_i_y_q <= cfg_wdata_i;
        CfgGainDY:  gain_d_y_q <= cfg_wdata_i;
        CfgTargetX: target_x_q <= cfg_wdata_i[CoordW-1:0];
        CfgTargetY: target_y_q <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Stage occupancy and object flags
  logic      v1_q, v1_d, v2_q, v2_d;
  logic      pres_s1_q, pres_s2_q;
  logic      accept, load_s2, merge_free;
  lane_ctl_t ctl;

  assign load_s2    = v1_q && (!v2_q || merge_free);
  assign in_i.ready = !v1_q || load_s2;
  assign accept     = in_i.valid && in_i.ready;
  assign v1_d       = accept ? 1'b1 : (load_s2 ? 1'b0 : v1_q);
  assign v2_d       = load_s2 ? 1'b1 : (merge_free ? 1'b0 : v2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pres_s1_q <= in_i.object_present;
    end
    if (load_s2) begin
      pres_s2_q <= pres_s1_q;
    end
  end

  always_comb begin
    ctl.load_s1    = accept;
    ctl.present_s1 = in_i.object_present;
    ctl.load_s2    = load_s2;
    ctl.present_s2 = pres_s2_q;
  end

  // Axis lanes
  logic signed [DriveW-1:0] drive_x, drive_y;

  dapt_lane #(
    .IntegralBits (IntegralBits),
    .GainFracBits (GainFracBits)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .target_i (target_x_q),
    .centre_i (in_i.centre_x),
    .gain_p_i (gain_p_x_q),
    .gain_i_i (gain_i_x_q),
    .gain_d_i (gain_d_x_q),
    .drive_o  (drive_x)
  );

  dapt_lane #(
    .IntegralBits (IntegralBits),
    .GainFracBits (GainFracBits)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .target_i (target_y_q),
    .centre_i (in_i.centre_y),
    .gain_p_i (gain_p_y_q),
    .gain_i_i (gain_i_y_q),
    .gain_d_i (gain_d_y_q),
    .drive_o  (drive_y)
  );

  // Output merge
  dapt_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v2_q),
    .present_i (pres_s2_q),
    .drive_x_i (drive_x),
    .drive_y_i (drive_y),
    .free_o    (merge_free),
    .out_o     (out_o)
  );

  // An accepted item occupies stage 1 next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted item lost at stage 1");

  // A product-stage item held by a stalled output stays put
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !merge_free) |=> v2_q && $stable(pres_s2_q))
    else $error("product stage dropped while stalled");

  // Stage 1 occupied and not moving blocks input
  a_s1_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && !merge_free) |-> !in_i.ready)
    else $error("input accepted over a held stage");

endmodule

>>> hw/rtl/dapt_lane.sv
// One PID axis: error, saturating integral and derivative, gain products, drive.
module dapt_lane #(
  parameter int unsigned IntegralBits = 21,
  parameter int unsigned GainFracBits = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dapt_pkg::lane_ctl_t                ctl_i,
  input  logic [dapt_pkg::CoordW-1:0]        target_i,
  input  logic [dapt_pkg::CoordW-1:0]        centre_i,
  input  logic [dapt_pkg::GainW-1:0]         gain_p_i,
  input  logic [dapt_pkg::GainW-1:0]         gain_i_i,
  input  logic [dapt_pkg::GainW-1:0]         gain_d_i,
  output logic signed [dapt_pkg::DriveW-1:0] drive_o
);
  import dapt_pkg::*;

  localparam int unsigned SumW = IntegralBits;
  localparam int unsigned ProdPW = GainW + 1 + ErrW;
  localparam int unsigned ProdIW = GainW + 1 + SumW;
  localparam int unsigned ProdDW = GainW + 1 + DerW;
  localparam int unsigned AccW   = SumW + GainW + 3;

  localparam logic signed [SumW:0] SumLim = signed'({2'b00, {(SumW-1){1'b1}}});
  localparam logic signed [AccW-1:0] TruncBias =
    signed'({{(AccW-GainFracBits){1'b0}}, {GainFracBits{1'b1}}});
  localparam logic signed [AccW-1:0] AccLim = AccW'(DriveLimit);

  // Loop state
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [ErrW-1:0] last_q, last_d;

  // Stage 1 and product stage
  logic signed [ErrW-1:0]   err_s1_q;
  logic signed [SumW-1:0]   sum_s1_q;
  logic signed [DerW-1:0]   der_s1_q;
  logic signed [ProdPW-1:0] prod_p_q, prod_p_d;
  logic signed [ProdIW-1:0] prod_i_q, prod_i_d;
  logic signed [ProdDW-1:0] prod_d_q, prod_d_d;

  logic signed [ErrW-1:0] err;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW:0]   sum_sat;
  logic signed [DerW-1:0] der;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] acc_q8;

  // Error, clamped integral and difference to the previous error
  always_comb begin
    err      = $signed({1'b0, target_i}) - $signed({1'b0, centre_i});
    sum_wide = (SumW+1)'(sum_q) + (SumW+1)'(err);
    if (sum_wide > SumLim) begin
      sum_sat = SumLim;
    end else if (sum_wide < -SumLim) begin
      sum_sat = -SumLim;
    end else begin
      sum_sat = sum_wide;
    end
    der = DerW'(err) - DerW'(last_q);
  end

  // Present object: take the clamped integral and store the error; missing object: clear the integral
  always_comb begin
    sum_d  = sum_q;
    last_d = last_q;
    if (ctl_i.load_s1) begin
      if (ctl_i.present_s1) begin
        sum_d  = sum_sat[SumW-1:0];
        last_d = err;
      end else begin
        sum_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
    end else begin
      sum_q  <= sum_d;
      last_q <= last_d;
    end
  end

  // Gain products
  always_comb begin
    prod_p_d = $signed({1'b0, gain_p_i}) * err_s1_q;
    prod_i_d = $signed({1'b0, gain_i_i}) * sum_s1_q;
    prod_d_d = $signed({1'b0, gain_d_i}) * der_s1_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s1) begin
      err_s1_q <= err;
      sum_s1_q <= sum_sat[SumW-1:0];
      der_s1_q <= der;
    end
    if (ctl_i.load_s2) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  // Sum, truncate toward zero, saturate; zero drive when no object is present
  always_comb begin
    acc = AccW'(prod_p_q) + AccW'(prod_i_q) + AccW'(prod_d_q);
    if (acc[AccW-1]) begin
      acc_q8 = (acc + TruncBias) >>> GainFracBits;
    end else begin
      acc_q8 = acc >>> GainFracBits;
    end
    if (!ctl_i.present_s2) begin
      drive_o = '0;
    end else if (acc_q8 > AccLim) begin
      drive_o = DriveW'(DriveLimit);
    end else if (acc_q8 < -AccLim) begin
      drive_o = -DriveW'(DriveLimit);
    end else begin
      drive_o = acc_q8[DriveW-1:0];
    end
  end

  // Integral never leaves its clamp range
  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((SumW+1)'(sum_q) <= SumLim) && ((SumW+1)'(sum_q) >= -SumLim))
    else $error("integral outside clamp range");

  // Missing object clears the integral and keeps the previous error
  a_clear_on_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.load_s1 && !ctl_i.present_s1) |=> (sum_q == '0) && $stable(last_q))
    else $error("integral not cleared on missing object");

  // Loop state only moves when an item is accepted
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.load_s1 |=> $stable(sum_q) && $stable(last_q))
    else $error("loop state changed without an item");

endmodule

>>> hw/rtl/dapt_merge.sv
// Merge both axis drives and the brake flag into the registered output item.
module dapt_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               present_i,
  input  logic signed [dapt_pkg::DriveW-1:0] drive_x_i,
  input  logic signed [dapt_pkg::DriveW-1:0] drive_y_i,
  output logic                               free_o,
  dapt_out_if.source                         out_o
);
  import dapt_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [DriveW-1:0] drive_x_q;
  logic signed [DriveW-1:0] drive_y_q;
  logic                     brake_q;
  logic                     load;

  // Take a new item when the register is empty or being drained
  assign free_o  = !valid_q || out_o.ready;
  assign load    = valid_i && free_o;
  assign valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_x_q <= drive_x_i;
      drive_y_q <= drive_y_i;
      brake_q   <= !present_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.drive_x = drive_x_q;
  assign out_o.drive_y = drive_y_q;
  assign out_o.brake   = brake_q;

  // Brake goes with zero drive on both axes
  a_brake_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && brake_q) |-> (drive_x_q == '0) && (drive_y_q == '0))
    else $error("drive nonzero while braking");

  // Drives stay within the percent limit
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (drive_x_q <= DriveW'(DriveLimit)) && (drive_x_q >= -DriveW'(DriveLimit))
             && (drive_y_q <= DriveW'(DriveLimit)) && (drive_y_q >= -DriveW'(DriveLimit)))
    else $error("drive outside limit");

  // A loaded item is shown in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("loaded item not presented");

endmodule
